>>> design/mdil_pkg.sv
// ============================================================================
// mdil_pkg: shared types and constants for the 3D mask dilation block
// Command codes, register indexes and the control structures that pass
// between the sequencer, the row unit and the per-bit lanes.
// ============================================================================
package mdil_pkg;

    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 12;
    localparam int BITS_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SIZE_W     = 7;
    localparam int PASS_W     = 8;
    // Row counter holds up to 64 * 64 rows plus one look-ahead issue.
    localparam int ROW_CNT_W  = 13;
    // Coordinates along y and z stay below 64.
    localparam int COORD_W    = 6;
    localparam int DLY_DEPTH  = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_COUNT    = 2'd0,
        CFG_Y_COUNT    = 2'd1,
        CFG_Z_COUNT    = 2'd2,
        CFG_PASS_COUNT = 2'd3
    } t_cfg_idx;

    // Which face neighbors along y and z lie inside the volume.
    typedef struct packed {
        logic ym;
        logic yp;
        logic zm;
        logic zp;
    } t_nbr_en;

    // One row on its way through the compute stage.
    typedef struct packed {
        logic                 valid;
        logic [ROW_CNT_W-1:0] row;
        logic [COORD_W-1:0]   y;
        t_nbr_en              en;
        logic                 ny_one;
    } t_stage;

    // A finished row headed for the destination bank.
    typedef struct packed {
        logic                 valid;
        logic [ROW_CNT_W-1:0] row;
    } t_wr;

endpackage

>>> design/mdil_bank.sv
// ============================================================================
// mdil_bank: one mask bank
// Row memory with one write port and two registered read ports.
// ============================================================================
module mdil_bank #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_q_a,
    output logic [WIDTH-1:0] o_q_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q_a;
    logic [WIDTH-1:0] r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_a <= r_mem[i_raddr_a];
        r_q_b <= r_mem[i_raddr_b];
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule

>>> design/mdil_lane.sv
// ============================================================================
// mdil_lane: one x-sample of the dilation
// Combines a sample with its six face neighbors and applies the row mask.
// ============================================================================
module mdil_lane (
    input  logic             i_mid,
    input  logic             i_left,
    input  logic             i_right,
    input  logic             i_ym,
    input  logic             i_yp,
    input  logic             i_zm,
    input  logic             i_zp,
    input  mdil_pkg::t_nbr_en i_en,
    input  logic             i_mask,
    output logic            o_bit
);

    import mdil_pkg::*;

    logic w_any;

    always_comb begin
        w_any = i_mid | i_left | i_right
              | (i_en.ym & i_ym) | (i_en.yp & i_yp)
              | (i_en.zm & i_zm) | (i_en.zp & i_zp);
        o_bit = w_any & i_mask;
    end

endmodule

>>> design/mdil_row_unit.sv
// ============================================================================
// mdil_row_unit: row window, lanes and merge register
// Keeps the previous two rows and a one-plane delay line so that every row
// sees all six neighbors, runs one lane per x-sample and registers the row.
// ============================================================================
module mdil_row_unit #(
    parameter int ROW_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_issue,
    input  logic [mdil_pkg::COORD_W-1:0]      i_dly_raddr,
    input  mdil_pkg::t_stage                  i_stage,
    input  logic [ROW_WIDTH-1:0]              i_q_near,
    input  logic [ROW_WIDTH-1:0]              i_q_far,
    input  logic [ROW_WIDTH-1:0]              i_mask,
    output mdil_pkg::t_wr                     o_wr,
    output logic [ROW_WIDTH-1:0]              o_wr_data
);

    import mdil_pkg::*;

    logic [ROW_WIDTH-1:0] r_c1;
    logic [ROW_WIDTH-1:0] r_c2;
    logic [ROW_WIDTH-1:0] r_dly_q;
    logic [ROW_WIDTH-1:0] r_dly_mem [DLY_DEPTH];
    logic [ROW_WIDTH-1:0] w_zm;
    logic [ROW_WIDTH-1:0] w_lane;
    logic                 r_wr_valid;
    logic [ROW_CNT_W-1:0] r_wr_row;
    logic [ROW_WIDTH-1:0] r_wr_data;

    // On each issue the window shifts: r_c1 becomes the center row and
    // r_c2 the row before it, while i_q_near carries the row after it.
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_c1    <= i_q_near;
            r_c2    <= r_c1;
            r_dly_q <= r_dly_mem[i_dly_raddr];
        end
        if (i_stage.valid) begin
            r_dly_mem[i_stage.y] <= r_c1;
        end
    end

    // With one row per plane the delay line would collide with itself; the
    // row one plane back is then simply the previous row.
    assign w_zm = i_stage.ny_one ? r_c2 : r_dly_q;

    for (genvar g = 0; g < ROW_WIDTH; g++) begin : g_lane
        logic w_left;
        logic w_right;
        if (g > 0) begin : g_l
            assign w_left = r_c1[g-1];
        end else begin : g_l0
            assign w_left = 1'b0;
        end
        if (g < ROW_WIDTH - 1) begin : g_r
            assign w_right = r_c1[g+1];
        end else begin : g_r0
            assign w_right = 1'b0;
        end
        mdil_lane u_lane (
            .i_mid   (r_c1[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_ym    (r_c2[g]),
            .i_yp    (i_q_near[g]),
            .i_zm    (w_zm[g]),
            .i_zp    (i_q_far[g]),
            .i_en    (i_stage.en),
            .i_mask  (i_mask[g]),
            .o_bit   (w_lane[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= i_stage.valid;
        end
        r_wr_row  <= i_stage.row;
        r_wr_data <= w_lane;
    end

    assign o_wr.valid = r_wr_valid;
    assign o_wr.row   = r_wr_row;
    assign o_wr_data  = r_wr_data;

endmodule

>>> design/mask_dilation_3d_core.sv
// ============================================================================
// mask_dilation_3d_core: 6-connected binary dilation of a 3D mask
// Two row banks, a pass sequencer and a lane-parallel row unit.
// ============================================================================
// A write, read or unused command is accepted while busy is low and its
// result strobes on o_done in the next cycle; such commands may follow each
// other in every cycle. A run keeps busy high until its last pass is done
// and strobes its result in the first cycle in which busy is low again; a
// run with zero passes answers in the next cycle. The pass sequencer reads
// one row per cycle through the two read ports of the source bank and then
// drains the row pipeline before the banks swap. The receiver cannot stall:
// each result is shown for exactly one cycle. Every row of the volume must
// be written before the first run.
module mask_dilation_3d_core #(
    parameter int ROW_WIDTH = 64,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mdil_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mdil_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               start,
    input  logic [mdil_pkg::KIND_W-1:0]        i_kind,
    input  logic [mdil_pkg::INDEX_W-1:0]       i_row_index,
    input  logic [mdil_pkg::BITS_W-1:0]        i_row_bits,
    output logic                               busy,
    output logic                               o_done,
    output logic [mdil_pkg::BITS_W-1:0]        o_read_bits,
    output logic                               o_range_error,
    output logic                               o_done_res
);

    import mdil_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [SIZE_W-1:0] XMax = SIZE_W'(ROW_WIDTH);
    localparam logic [SIZE_W-1:0] YMax = (MAX_ROWS < 64) ? SIZE_W'(MAX_ROWS) : SIZE_W'(64);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    // Configuration registers.
    logic [SIZE_W-1:0] r_x_count;
    logic [SIZE_W-1:0] r_y_count;
    logic [SIZE_W-1:0] r_z_count;
    logic [PASS_W-1:0] r_pass_count;

    // Sequencer state.
    t_state               r_state;
    logic                 r_cur_bank;
    logic [PASS_W-1:0]    r_pass_ctr;
    logic [ROW_CNT_W-1:0] r_idx;
    logic [COORD_W-1:0]   r_yi;
    logic [COORD_W-1:0]   r_zi;
    logic [COORD_W-1:0]   r_yp;
    logic [COORD_W-1:0]   r_zp;
    t_stage               r_stage;
    logic                 r_done;
    logic                 r_err;
    logic                 r_rd_ok;

    // Derived volume size.
    logic [SIZE_W-1:0]    w_eff_x;
    logic [SIZE_W-1:0]    w_eff_y;
    logic [SIZE_W-1:0]    w_eff_z;
    logic [SIZE_W-1:0]    w_zcap;
    logic [SIZE_W-1:0]    zcap_tab [64];
    logic [ROW_CNT_W-1:0] w_rows;
    logic [ROW_WIDTH-1:0] w_mask;

    logic                 w_accept;
    logic                 w_in_range;
    logic                 w_cmd_wr;
    logic [ROW_WIDTH-1:0] w_cmd_data;
    logic                 w_issue;
    logic                 w_y_wrap;

    // Bank ports.
    logic [AW-1:0]        w_raddr_a;
    logic [AW-1:0]        w_raddr_b;
    logic [AW-1:0]        w_waddr;
    logic [ROW_WIDTH-1:0] w_wdata;
    logic                 w_we_a;
    logic                 w_we_b;
    logic [ROW_WIDTH-1:0] w_qa_a;
    logic [ROW_WIDTH-1:0] w_qa_b;
    logic [ROW_WIDTH-1:0] w_qb_a;
    logic [ROW_WIDTH-1:0] w_qb_b;
    logic [ROW_WIDTH-1:0] w_q_near;
    logic [ROW_WIDTH-1:0] w_q_far;
    t_wr                  w_wr;
    logic [ROW_WIDTH-1:0] w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count    <= SIZE_W'(64);
            r_y_count    <= SIZE_W'(64);
            r_z_count    <= SIZE_W'(64);
            r_pass_count <= PASS_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_X_COUNT:    r_x_count    <= i_cfg_data[SIZE_W-1:0];
                CFG_Y_COUNT:    r_y_count    <= i_cfg_data[SIZE_W-1:0];
                CFG_Z_COUNT:    r_z_count    <= i_cfg_data[SIZE_W-1:0];
                CFG_PASS_COUNT: r_pass_count <= i_cfg_data[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    // Largest plane count that keeps the volume within the banks, per y size.
    for (genvar g = 0; g < 64; g++) begin : g_zcap
        localparam int ZQ = MAX_ROWS / (g + 1);
        assign zcap_tab[g] = (ZQ > 64) ? SIZE_W'(64) : ((ZQ < 1) ? SIZE_W'(1) : SIZE_W'(ZQ));
    end

    always_comb begin
        if (r_x_count == '0) begin
            w_eff_x = SIZE_W'(1);
        end else if (r_x_count > XMax) begin
            w_eff_x = XMax;
        end else begin
            w_eff_x = r_x_count;
        end
        if (r_y_count == '0) begin
            w_eff_y = SIZE_W'(1);
        end else if (r_y_count > YMax) begin
            w_eff_y = YMax;
        end else begin
            w_eff_y = r_y_count;
        end
        w_zcap = zcap_tab[COORD_W'(w_eff_y - SIZE_W'(1))];
        if (r_z_count == '0) begin
            w_eff_z = SIZE_W'(1);
        end else if (r_z_count > w_zcap) begin
            w_eff_z = w_zcap;
        end else begin
            w_eff_z = r_z_count;
        end
        w_rows = ROW_CNT_W'(w_eff_y) * ROW_CNT_W'(w_eff_z);
    end

    for (genvar g = 0; g < ROW_WIDTH; g++) begin : g_mask
        assign w_mask[g] = (SIZE_W'(g) < w_eff_x);
    end

    assign w_accept   = start && !busy && i_rst_n;
    assign w_in_range = ({1'b0, i_row_index} < w_rows);
    assign w_cmd_wr   = w_accept && (t_kind'(i_kind) == KIND_WRITE) && w_in_range;
    assign w_cmd_data = i_row_bits[ROW_WIDTH-1:0] & w_mask;
    assign w_issue    = (r_state == S_ISSUE);
    assign w_y_wrap   = ({1'b0, r_yi} + SIZE_W'(1) == w_eff_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur_bank    <= 1'b0;
            r_pass_ctr    <= '0;
            r_idx         <= '0;
            r_yi          <= '0;
            r_zi          <= '0;
            r_yp          <= '0;
            r_zp          <= '0;
            r_stage.valid <= 1'b0;
            r_done        <= 1'b0;
            r_err         <= 1'b0;
            r_rd_ok       <= 1'b0;
        end else begin
            r_done        <= 1'b0;
            r_err         <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_stage.valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (t_kind'(i_kind))
                            KIND_WRITE: begin
                                r_done <= 1'b1;
                                r_err  <= !w_in_range;
                            end
                            KIND_READ: begin
                                r_done  <= 1'b1;
                                r_err   <= !w_in_range;
                                r_rd_ok <= w_in_range;
                            end
                            KIND_RUN: begin
                                if (r_pass_count == '0) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state    <= S_ISSUE;
                                    r_pass_ctr <= '0;
                                    r_idx      <= '0;
                                    r_yi       <= '0;
                                    r_zi       <= '0;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    // The first issue only primes the window; each later one
                    // releases the row before it into the compute stage.
                    if (r_idx != '0) begin
                        r_stage.valid  <= 1'b1;
                        r_stage.row    <= r_idx - ROW_CNT_W'(1);
                        r_stage.y      <= r_yp;
                        r_stage.en.ym  <= (r_yp != '0);
                        r_stage.en.yp  <= ({1'b0, r_yp} + SIZE_W'(1) < w_eff_y);
                        r_stage.en.zm  <= (r_zp != '0);
                        r_stage.en.zp  <= ({1'b0, r_zp} + SIZE_W'(1) < w_eff_z);
                        r_stage.ny_one <= (w_eff_y == SIZE_W'(1));
                    end
                    r_yp <= r_yi;
                    r_zp <= r_zi;
                    if (w_y_wrap) begin
                        r_yi <= '0;
                        r_zi <= r_zi + COORD_W'(1);
                    end else begin
                        r_yi <= r_yi + COORD_W'(1);
                    end
                    if (r_idx == w_rows) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + ROW_CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    // Swap only once the last row has landed in the other bank.
                    if (!r_stage.valid && !w_wr.valid) begin
                        r_cur_bank <= !r_cur_bank;
                        if (r_pass_ctr + PASS_W'(1) == r_pass_count) begin
                            r_state    <= S_IDLE;
                            r_pass_ctr <= '0;
                            r_done     <= 1'b1;
                        end else begin
                            r_state    <= S_ISSUE;
                            r_pass_ctr <= r_pass_ctr + PASS_W'(1);
                        end
                        r_idx <= '0;
                        r_yi  <= '0;
                        r_zi  <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_raddr_a = w_issue ? AW'(r_idx) : AW'(i_row_index);
    assign w_raddr_b = AW'(r_idx + ROW_CNT_W'(w_eff_y) - ROW_CNT_W'(1));
    assign w_waddr   = w_wr.valid ? AW'(w_wr.row) : AW'(i_row_index);
    assign w_wdata   = w_wr.valid ? w_wr_data : w_cmd_data;
    // A pass writes the bank that is not current; commands write the current one.
    assign w_we_a    = (w_cmd_wr && !r_cur_bank) || (w_wr.valid && r_cur_bank);
    assign w_we_b    = (w_cmd_wr && r_cur_bank) || (w_wr.valid && !r_cur_bank);

    mdil_bank #(
        .WIDTH (ROW_WIDTH),
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_bank_a (
        .i_clk     (i_clk),
        .i_we      (w_we_a),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_q_a     (w_qa_a),
        .o_q_b     (w_qb_a)
    );

    mdil_bank #(
        .WIDTH (ROW_WIDTH),
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_bank_b (
        .i_clk     (i_clk),
        .i_we      (w_we_b),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_q_a     (w_qa_b),
        .o_q_b     (w_qb_b)
    );

    assign w_q_near = r_cur_bank ? w_qa_b : w_qa_a;
    assign w_q_far  = r_cur_bank ? w_qb_b : w_qb_a;

    mdil_row_unit #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_row_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_dly_raddr (r_yp),
        .i_stage     (r_stage),
        .i_q_near    (w_q_near),
        .i_q_far     (w_q_far),
        .i_mask      (w_mask),
        .o_wr        (w_wr),
        .o_wr_data   (w_wr_data)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_range_error = r_err;
    assign o_done_res    = r_done;
    assign o_read_bits   = r_rd_ok ? BITS_W'(w_q_near & w_mask) : '0;

endmodule

>>> design/mdil_checker.sv
// ============================================================================
// mdil_checker: port-level checks for the 3D mask dilation block
// Watches the command and result ports over time; bound to the top level.
// ============================================================================
module mdil_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [mdil_pkg::KIND_W-1:0]   i_kind,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic [mdil_pkg::BITS_W-1:0]   o_read_bits,
    input  logic                          o_range_error,
    input  logic                          o_done_res
);

    import mdil_pkg::*;

    // Any transaction other than a run answers in the very next cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind != KIND_RUN)) |=> o_done)
        else $error("command other than run did not answer in the next cycle");

    // A run in progress never shows a result.
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result strobe while a run is in progress");

    // An accepted run must either raise busy or deliver its result.
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_RUN)) |=> (busy || o_done))
        else $error("run transaction neither started nor answered");

    // Error and read data only appear with a result, and every result is complete.
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_done |-> (!o_range_error && (o_read_bits == '0))) and (o_done |-> o_done_res))
        else $error("result fields inconsistent with the strobe");

    // A flagged row index never returns data.
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_error |-> (o_read_bits == '0))
        else $error("read data returned with a range error");

endmodule

bind mask_dilation_3d_core mdil_checker u_mdil_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .i_kind        (i_kind),
    .busy          (busy),
    .o_done        (o_done),
    .o_read_bits   (o_read_bits),
    .o_range_error (o_range_error),
    .o_done_res    (o_done_res)
);

>>> tb/tb_top.sv
// ============================================================================
// tb_top: self-checking testbench for mask_dilation_3d_core
// Sends row writes, row reads, dilation runs and unused commands with random
// idle gaps over a series of volume sizes and pass counts. A scoreboard keeps
// its own two-bank copy of the mask, predicts each result and compares every
// strobed result with the oldest prediction, field by field.
// ============================================================================
module tb_top;
    import mdil_pkg::*;

    localparam int ROWS_MAX    = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [BITS_W-1:0] read_bits;
        logic              range_error;
        logic              done_res;
    } t_dil_result;

    class dilation_scoreboard;
        logic [BITS_W-1:0] plane_a [ROWS_MAX];
        logic [BITS_W-1:0] plane_b [ROWS_MAX];
        bit                cur_sel;
        logic [SIZE_W-1:0] x_reg;
        logic [SIZE_W-1:0] y_reg;
        logic [SIZE_W-1:0] z_reg;
        logic [PASS_W-1:0] pass_reg;
        t_dil_result       expected_q[$];
        int                fails;
        int                n_write;
        int                n_read;
        int                n_run;
        int                n_outside;
        int                n_unused;

        function new();
            cur_sel   = 1'b0;
            x_reg     = 7'd64;
            y_reg     = 7'd64;
            z_reg     = 7'd64;
            pass_reg  = 8'd1;
            fails     = 0;
            n_write   = 0;
            n_read    = 0;
            n_run     = 0;
            n_outside = 0;
            n_unused  = 0;
            for (int r = 0; r < ROWS_MAX; r++) begin
                plane_a[r] = '0;
                plane_b[r] = '0;
            end
        endfunction

        function int size_x();
            if (x_reg < 1) return 1;
            if (x_reg > 64) return 64;
            return int'(x_reg);
        endfunction

        function int size_y();
            if (y_reg < 1) return 1;
            if (y_reg > 64) return 64;
            return int'(y_reg);
        endfunction

        // The plane count is capped so that the volume fits the bank.
        function int size_z();
            int cap;
            cap = ROWS_MAX / size_y();
            if (cap > 64) cap = 64;
            if (cap < 1) cap = 1;
            if (z_reg < 1) return 1;
            if (z_reg > cap) return cap;
            return int'(z_reg);
        endfunction

        function int volume_rows();
            return size_y() * size_z();
        endfunction

        function logic [BITS_W-1:0] x_mask();
            if (size_x() >= 64) return '1;
            return (64'd1 << size_x()) - 64'd1;
        endfunction

        function logic [BITS_W-1:0] get_row(bit sel, int r);
            return sel ? plane_b[r] : plane_a[r];
        endfunction

        function void put_row(bit sel, int r, logic [BITS_W-1:0] v);
            if (sel) plane_b[r] = v;
            else plane_a[r] = v;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_X_COUNT:    x_reg = data[SIZE_W-1:0];
                CFG_Y_COUNT:    y_reg = data[SIZE_W-1:0];
                CFG_Z_COUNT:    z_reg = data[SIZE_W-1:0];
                CFG_PASS_COUNT: pass_reg = data;
                default: ;
            endcase
        endfunction

        // One pass reads the current bank, writes the other one, then swaps.
        function void dilate_once();
            int                ny;
            int                nz;
            int                r;
            bit                src;
            logic [BITS_W-1:0] c;
            logic [BITS_W-1:0] n;
            logic [BITS_W-1:0] m;
            ny  = size_y();
            nz  = size_z();
            m   = x_mask();
            src = cur_sel;
            for (int z = 0; z < nz; z++) begin
                for (int y = 0; y < ny; y++) begin
                    r = z * ny + y;
                    c = get_row(src, r);
                    n = c | (c << 1) | (c >> 1);
                    if (y > 0) n |= get_row(src, r - 1);
                    if (y + 1 < ny) n |= get_row(src, r + 1);
                    if (z > 0) n |= get_row(src, r - ny);
                    if (z + 1 < nz) n |= get_row(src, r + ny);
                    put_row(!src, r, n & m);
                end
            end
            cur_sel = !cur_sel;
        endfunction

        function void note_command(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                   logic [BITS_W-1:0] bits);
            t_dil_result res;
            res.read_bits   = '0;
            res.range_error = 1'b0;
            res.done_res    = 1'b1;
            if (kind == KIND_WRITE || kind == KIND_READ) begin
                if (int'(idx) >= volume_rows()) begin
                    res.range_error = 1'b1;
                    n_outside++;
                end else if (kind == KIND_WRITE) begin
                    put_row(cur_sel, int'(idx), bits & x_mask());
                    n_write++;
                end else begin
                    res.read_bits = get_row(cur_sel, int'(idx)) & x_mask();
                    n_read++;
                end
            end else if (kind == KIND_RUN) begin
                for (int p = 0; p < int'(pass_reg); p++) dilate_once();
                n_run++;
            end else begin
                n_unused++;
            end
            expected_q = {expected_q, res};
        endfunction

        function void check_result(logic [BITS_W-1:0] rd, logic err, logic done);
            t_dil_result exp_res;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("MISMATCH: result with nothing expected: read_bits=%h err=%b",
                             rd, err);
                return;
            end
            exp_res = expected_q.pop_front();
            if (rd !== exp_res.read_bits || err !== exp_res.range_error
                    || done !== exp_res.done_res) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("MISMATCH: read_bits exp %h got %h, range_error exp %b got %b, %s",
                             exp_res.read_bits, rd, exp_res.range_error, err,
                             $sformatf("done_res exp %b got %b", exp_res.done_res, done));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic [KIND_W-1:0]     i_kind;
    logic [INDEX_W-1:0]    i_row_index;
    logic [BITS_W-1:0]     i_row_bits;
    logic                  busy;
    logic                  o_done;
    logic [BITS_W-1:0]     o_read_bits;
    logic                  o_range_error;
    logic                  o_done_res;

    dilation_scoreboard sb;
    bit                 no_idle;
    int                 cycle_count;
    int                 settings_run;

    mask_dilation_3d_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .i_kind        (i_kind),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .busy          (busy),
        .o_done        (o_done),
        .o_read_bits   (o_read_bits),
        .o_range_error (o_range_error),
        .o_done_res    (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_read_bits, o_range_error, o_done_res);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [BITS_W-1:0] random_row_bits();
        logic [BITS_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 64'd1 << $urandom_range(0, 63);
            1: v = {$urandom, $urandom};
            2: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: begin
                if ($urandom_range(0, 3) == 0) v = '0;
                else v = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            end
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at a falling edge after the idle gap.
    task automatic send(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                        logic [BITS_W-1:0] bits);
        int gap;
        i_kind      = kind;
        i_row_index = idx;
        i_row_bits  = bits;
        start       = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(kind, idx, bits);
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Changing the volume invalidates the row layout, so every setting is
    // followed by a full rewrite of the volume.
    task automatic set_volume(logic [7:0] xv, logic [7:0] yv, logic [7:0] zv,
                              logic [7:0] pv);
        drain();
        cfg_write(CFG_X_COUNT, xv);
        cfg_write(CFG_Y_COUNT, yv);
        cfg_write(CFG_Z_COUNT, zv);
        cfg_write(CFG_PASS_COUNT, pv);
        settings_run++;
        for (int r = 0; r < sb.volume_rows(); r++)
            send(KIND_WRITE, INDEX_W'(r), random_row_bits());
    endtask

    task automatic random_phase(int n_items, int run_pct);
        int rows;
        int pick;
        int idx;
        rows = sb.volume_rows();
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, rows - 1);
            if (pick < run_pct) begin
                send(KIND_RUN, INDEX_W'($urandom), random_row_bits());
            end else if (pick < 45) begin
                send(KIND_WRITE, INDEX_W'(idx), random_row_bits());
            end else if (pick < 82) begin
                send(KIND_READ, INDEX_W'(idx), random_row_bits());
            end else if (pick < 93 && rows < ROWS_MAX) begin
                idx = $urandom_range(rows, ROWS_MAX - 1);
                send($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, INDEX_W'(idx),
                     random_row_bits());
            end else begin
                send(KIND_UNUSED, INDEX_W'($urandom), random_row_bits());
            end
            if ($urandom_range(0, 39) == 0) drain();
        end
    endtask

    initial begin
        sb           = new();
        settings_run = 0;
        no_idle      = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        start        = 1'b0;
        i_kind       = KIND_WRITE;
        i_row_index  = '0;
        i_row_bits   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on a 5 x 3 x 2 volume with one pass per run.
        drain();
        cfg_write(CFG_X_COUNT, 8'd5);
        cfg_write(CFG_Y_COUNT, 8'd3);
        cfg_write(CFG_Z_COUNT, 8'd2);
        cfg_write(CFG_PASS_COUNT, 8'd1);
        settings_run++;
        send(KIND_WRITE, 12'hFFF, '1);
        send(KIND_READ, 12'd6, '0);
        send(KIND_UNUSED, 12'd0, '1);
        send(KIND_WRITE, 12'd0, '1);
        send(KIND_WRITE, 12'd1, '0);
        send(KIND_WRITE, 12'd2, 64'h8000_0000_0000_0001);
        send(KIND_WRITE, 12'd3, '0);
        send(KIND_WRITE, 12'd4, 64'h0000_0000_0000_0004);
        send(KIND_WRITE, 12'd5, '0);
        send(KIND_READ, 12'd0, '0);
        send(KIND_READ, 12'd2, '0);
        send(KIND_RUN, 12'd0, '0);
        for (int r = 0; r < 6; r++) send(KIND_READ, INDEX_W'(r), '0);
        send(KIND_UNUSED, 12'hFFF, '1);
        send(KIND_WRITE, 12'd5, '1);
        send(KIND_READ, 12'd5, '0);

        // Single row with the largest pass count.
        set_volume(8'd64, 8'd1, 8'd1, 8'd255);
        random_phase(60, 5);
        // x of zero clamps to one sample.
        set_volume(8'd0, 8'd4, 8'd4, 8'd3);
        random_phase(90, 6);
        // Oversized x and z clamp; a column of 64 planes.
        no_idle = 1'b1;
        set_volume(8'hFF, 8'd1, 8'd127, 8'd2);
        random_phase(90, 6);
        no_idle = 1'b0;
        set_volume(8'd33, 8'd64, 8'd1, 8'd1);
        random_phase(90, 6);
        // Oversized x and y clamp to 64 samples and 64 rows, filled back to back.
        no_idle = 1'b1;
        set_volume(8'd127, 8'd127, 8'd2, 8'd2);
        random_phase(40, 3);
        no_idle = 1'b0;
        // Runs with zero passes must leave the mask alone.
        set_volume(8'd17, 8'd3, 8'd5, 8'd0);
        random_phase(80, 10);

        for (int ph = 0; ph < 4; ph++) begin
            no_idle = ($urandom_range(0, 2) == 0);
            set_volume(8'($urandom_range(0, 255)),
                       {1'($urandom), 7'($urandom_range(1, 8))},
                       {1'($urandom), 7'($urandom_range(1, 8))},
                       8'($urandom_range(0, 5)));
            random_phase(50, 6);
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d writes, %0d reads, %0d runs, %0d out-of-volume and %0d unused",
                 sb.n_write, sb.n_read, sb.n_run, sb.n_outside, sb.n_unused);
        $display("commands over %0d register settings in %0d cycles.", settings_run,
                 cycle_count);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d failing results, %0d expectations left", sb.fails, sb.pending());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
